@@ rtl/pcbd_pkg.sv @@
// Shared types and constants of the prefix code bit decoder.
package pcbd_pkg;

    localparam int BYTE_BITS = 8;

    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [7:0]  code_byte;
        logic [3:0]  bit_count;
        logic [7:0]  entry_index;
        logic [31:0] entry_code;
        logic [5:0]  entry_length;
        logic [7:0]  entry_symbol;
    } t_in_item;

    typedef struct packed {
        logic [7:0] decoded_symbol;
        logic       overflow_error;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic [31:0] code;
        logic [5:0]  length;
        logic [7:0]  symbol;
    } t_entry;

    typedef struct packed {
        logic       en;
        logic [7:0] addr;
        t_entry     data;
    } t_tbl_wr;

endpackage

@@ rtl/pcbd_if.sv @@
// Valid/ready channel interfaces for the input and result streams.
interface pcbd_in_if import pcbd_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pcbd_out_if import pcbd_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/prefix_code_bit_decoder_core.sv @@
// Top level of the prefix code bit decoder: bit sequencer and table scan.
//
//   channel | direction | payload                                    | handshake
//   i_in    | in        | mode, code_byte, bit_count, entry_* fields | valid/ready
//   o_out   | out       | decoded_symbol, overflow_error, last        | valid/ready
//
// A load transaction writes one table slot. A decode transaction consumes the bits one
// by one; for each bit it shifts the running code and scans the table, one memory
// read per slot through its single read port, stopping at the first match, and
// then posts each result.
// Reset clears the valid marks, the running code and all handshake state.
// A stalled result output holds the sequencer; input is accepted only while idle.
module prefix_code_bit_decoder_core import pcbd_pkg::*; #(
    parameter int TABLE_ENTRIES = 256,
    parameter int MAX_CODE_LEN  = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    pcbd_in_if.sink           i_in,
    pcbd_out_if.source        o_out
);

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int RW = MAX_CODE_LEN;
    localparam int LW = $clog2(MAX_CODE_LEN + 1);
    localparam int CW = (LW > 6) ? LW : 6;

    typedef enum logic [2:0] {
        S_IDLE,
        S_NEXT,
        S_SCAN,
        S_POST,
        S_FLUSH
    } t_state;

    t_state    r_state, n_state;
    logic [7:0]    r_byte, n_byte;
    logic [3:0]    r_nbits, n_nbits;
    logic [3:0]    r_bit, n_bit;
    logic [RW-1:0] r_code, n_code;
    logic [RW-1:0] r_mask, n_mask;
    logic [LW-1:0] r_len, n_len;
    logic [AW-1:0] r_addr, n_addr;
    logic          r_live, n_live;
    logic          r_rd_last, n_rd_last;
    logic [7:0]    r_new_sym, n_new_sym;
    logic          r_new_err, n_new_err;
    logic          r_pend_v, n_pend_v;
    logic [7:0]    r_pend_sym, n_pend_sym;
    logic          r_pend_err, n_pend_err;
    logic          r_out_v, n_out_v;
    t_out_item     r_out, n_out;

    t_tbl_wr       tbl_wr;
    t_entry        rd_data;
    logic          rd_valid;
    logic [RW-1:0] code_ext;
    logic          match;
    logic          in_ready;
    logic          in_take;
    logic          out_free;

    pcbd_table #(
        .ENTRIES (TABLE_ENTRIES)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (tbl_wr),
        .i_rd_addr  (r_addr),
        .o_rd_data  (rd_data),
        .o_rd_valid (rd_valid)
    );

    // No transaction is taken while reset is held.
    assign in_ready = (r_state == S_IDLE) && i_rst_n;
    assign in_take  = i_in.valid && in_ready;
    assign out_free = !r_out_v || o_out.ready;

    always_comb begin
        tbl_wr.en          = in_take && (i_in.data.mode == MODE_LOAD);
        tbl_wr.addr        = i_in.data.entry_index;
        tbl_wr.data.code   = i_in.data.entry_code;
        tbl_wr.data.length = i_in.data.entry_length;
        tbl_wr.data.symbol = i_in.data.entry_symbol;
    end

    // Stored code widened or cut to the running code width; the running mask
    // then drops every bit above the running length.
    always_comb begin
        code_ext = '0;
        for (int i = 0; i < RW; i++) begin
            if (i < 32) begin
                code_ext[i] = rd_data.code[i];
            end
        end
    end

    assign match = r_live && rd_valid && (CW'(rd_data.length) == CW'(r_len))
                   && ((code_ext & r_mask) == r_code);

    always_comb begin
        n_state    = r_state;
        n_byte     = r_byte;
        n_nbits    = r_nbits;
        n_bit      = r_bit;
        n_code     = r_code;
        n_mask     = r_mask;
        n_len      = r_len;
        n_addr     = r_addr;
        n_live     = r_live;
        n_rd_last  = r_rd_last;
        n_new_sym  = r_new_sym;
        n_new_err  = r_new_err;
        n_pend_v   = r_pend_v;
        n_pend_sym = r_pend_sym;
        n_pend_err = r_pend_err;
        n_out_v    = r_out_v;
        n_out      = r_out;

        if (r_out_v && o_out.ready) begin
            n_out_v = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_take && (i_in.data.mode == MODE_DECODE)) begin
                    n_byte  = i_in.data.code_byte;
                    n_nbits = (i_in.data.bit_count > 4'(BYTE_BITS)) ?
                              4'(BYTE_BITS) : i_in.data.bit_count;
                    n_bit   = '0;
                    n_state = S_NEXT;
                end
            end
            S_NEXT: begin
                if (r_bit == r_nbits) begin
                    n_state = S_FLUSH;
                end else begin
                    n_code  = RW'({r_code, r_byte[BYTE_BITS-1]});
                    n_mask  = RW'({r_mask, 1'b1});
                    n_len   = r_len + LW'(1);
                    n_byte  = {r_byte[BYTE_BITS-2:0], 1'b0};
                    n_bit   = r_bit + 4'd1;
                    n_addr  = '0;
                    n_live  = 1'b0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                // The compare works on the slot read through the table's registered read port.
                if (match) begin
                    n_new_sym = rd_data.symbol;
                    n_new_err = 1'b0;
                    n_code    = '0;
                    n_mask    = '0;
                    n_len     = '0;
                    n_state   = S_POST;
                end else if (r_live && r_rd_last) begin
                    if (r_len == LW'(MAX_CODE_LEN)) begin
                        n_new_sym = '0;
                        n_new_err = 1'b1;
                        n_code    = '0;
                        n_mask    = '0;
                        n_len     = '0;
                        n_state   = S_POST;
                    end else begin
                        n_state = S_NEXT;
                    end
                end else begin
                    n_live    = 1'b1;
                    n_rd_last = (r_addr == AW'(TABLE_ENTRIES - 1));
                    if (r_addr != AW'(TABLE_ENTRIES - 1)) begin
                        n_addr = r_addr + AW'(1);
                    end
                end
            end
            S_POST: begin
                // A result is held back until the next one or the end of the
                // byte shows whether it is the last of this transaction.
                if (r_pend_v) begin
                    if (out_free) begin
                        n_out_v   = 1'b1;
                        n_out     = '{decoded_symbol: r_pend_sym,
                                      overflow_error: r_pend_err, last: 1'b0};
                        n_pend_sym = r_new_sym;
                        n_pend_err = r_new_err;
                        n_state    = S_NEXT;
                    end
                end else begin
                    n_pend_v   = 1'b1;
                    n_pend_sym = r_new_sym;
                    n_pend_err = r_new_err;
                    n_state    = S_NEXT;
                end
            end
            S_FLUSH: begin
                if (r_pend_v) begin
                    if (out_free) begin
                        n_out_v  = 1'b1;
                        n_out    = '{decoded_symbol: r_pend_sym,
                                     overflow_error: r_pend_err, last: 1'b1};
                        n_pend_v = 1'b0;
                        n_state  = S_IDLE;
                    end
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_bit     <= '0;
            r_nbits   <= '0;
            r_code    <= '0;
            r_mask    <= '0;
            r_len     <= '0;
            r_addr    <= '0;
            r_live    <= 1'b0;
            r_rd_last <= 1'b0;
            r_pend_v  <= 1'b0;
            r_out_v   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_bit     <= n_bit;
            r_nbits   <= n_nbits;
            r_code    <= n_code;
            r_mask    <= n_mask;
            r_len     <= n_len;
            r_addr    <= n_addr;
            r_live    <= n_live;
            r_rd_last <= n_rd_last;
            r_pend_v  <= n_pend_v;
            r_out_v   <= n_out_v;
        end
        r_byte     <= n_byte;
        r_new_sym  <= n_new_sym;
        r_new_err  <= n_new_err;
        r_pend_sym <= n_pend_sym;
        r_pend_err <= n_pend_err;
        r_out      <= n_out;
    end

    assign i_in.ready  = in_ready;
    assign o_out.valid = r_out_v;
    assign o_out.data  = r_out;

endmodule

@@ rtl/pcbd_table.sv @@
// Code table memory with per-slot valid marks and a registered read port.
module pcbd_table import pcbd_pkg::*; #(
    parameter int ENTRIES = 256,
    localparam int AW = $clog2(ENTRIES)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_tbl_wr       i_wr,
    input  logic [AW-1:0] i_rd_addr,
    output t_entry        o_rd_data,
    output logic          o_rd_valid
);

    t_entry             r_mem [ENTRIES];
    logic [ENTRIES-1:0] r_valid;
    t_entry             r_rd_data;
    logic               r_rd_valid;
    logic               wr_hit;

    // Slots beyond the table depth are silently dropped.
    assign wr_hit = i_wr.en && ({1'b0, i_wr.addr} < 9'(ENTRIES));

    always_ff @(posedge i_clk) begin
        if (wr_hit) begin
            r_mem[i_wr.addr[AW-1:0]] <= i_wr.data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (wr_hit) begin
                r_valid[i_wr.addr[AW-1:0]] <= 1'b1;
            end
            r_rd_valid <= r_valid[i_rd_addr];
        end
    end

    assign o_rd_data  = r_rd_data;
    assign o_rd_valid = r_rd_valid;

endmodule
